// File: rtl/qsort_pkg.sv
`default_nettype none
package qsort_pkg;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int VAL_W = 16;
	localparam int CNT_W = 12;

	typedef struct packed {
		logic load;
		logic start;
		logic pop;
		logic ld_pivot;
		logic rd_i;
		logic rd_j;
		logic inc_i;
		logic dec_j;
		logic wr_i;
		logic wr_j;
		logic wr_lo;
		logic push_r;
		logic push_l;
		logic emit;
		logic clear;
	} qs_cmd_t;

	typedef struct packed {
		logic stk_empty;
		logic lo_ge_hi;
		logic i_le_j;
		logic le_pivot;
		logic push_r_ok;
		logic push_l_ok;
		logic emit_last;
	} qs_sts_t;
endpackage
`default_nettype wire

// File: rtl/qsort_ram.sv
`default_nettype none
module qsort_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/qsort_dp.sv
`default_nettype none
module qsort_dp import qsort_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire qs_cmd_t                 cmd,
	output qs_sts_t                      sts,
	input  wire logic signed [VAL_W-1:0] in_value,
	output logic signed [VAL_W-1:0]      out_value,
	output logic [CNT_W-1:0]             out_count,
	output logic                         out_drop
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int NW = AW + 1;

	logic [NW-1:0] n_q, sp_q, k_q;
	logic [NW-1:0] n_nx;
	logic [AW-1:0] lo_q, hi_q;
	logic signed [AW+1:0] i_q, j_q;
	logic signed [VAL_W-1:0] piv_q, ei_q;
	logic piv_pend_q;
	logic [CNT_W-1:0] cnt_q;
	logic drop_q;

	logic we, swe;
	logic [AW-1:0] waddr, raddr, saddr_w, saddr_r;
	logic [VAL_W-1:0] wdata, rdata;
	logic [2*AW-1:0] swdata, srdata;

	qsort_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	qsort_ram #(.WIDTH(2*AW), .DEPTH(MAX_ITEMS)) u_stack (
		.clk(clk), .we(swe), .waddr(saddr_w), .wdata(swdata), .raddr(saddr_r),
		.rdata(srdata)
	);

	logic signed [AW+1:0] lo_x, hi_x;
	assign lo_x = {2'b00, lo_q};
	assign hi_x = {2'b00, hi_q};

	assign n_nx = (cmd.load && (n_q != NW'(MAX_ITEMS))) ? n_q + NW'(1) : n_q;

	always_comb begin
		we = 1'b0;
		waddr = k_q[AW-1:0];
		wdata = in_value;
		raddr = k_q[AW-1:0];
		if (cmd.load) begin
			we = (n_q != NW'(MAX_ITEMS));
			waddr = n_q[AW-1:0];
		end else if (cmd.wr_i) begin
			we = 1'b1; waddr = i_q[AW-1:0]; wdata = rdata;
		end else if (cmd.wr_j) begin
			we = 1'b1; waddr = j_q[AW-1:0]; wdata = ei_q;
		end else if (cmd.wr_lo) begin
			we = 1'b1; waddr = lo_q; wdata = rdata;
		end
		if (cmd.rd_i) raddr = cmd.inc_i ? AW'(i_q + 1) : i_q[AW-1:0];
		else if (cmd.rd_j) raddr = cmd.dec_j ? AW'(j_q - 1) : j_q[AW-1:0];
		else if (cmd.ld_pivot) raddr = lo_q;
		swe = cmd.push_r | cmd.push_l | cmd.start;
		saddr_w = sp_q[AW-1:0];
		if (cmd.start) swdata = {AW'(0), AW'(n_nx - NW'(1))};
		else if (cmd.push_r) swdata = {AW'(j_q + 1), hi_q};
		else swdata = {lo_q, AW'(j_q - 1)};
		saddr_r = AW'(sp_q - NW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0; sp_q <= '0; k_q <= '0; cnt_q <= '0; drop_q <= 1'b0;
			piv_pend_q <= 1'b0;
		end else begin
			piv_pend_q <= cmd.ld_pivot;
			if (cmd.load) begin
				if (n_q != NW'(MAX_ITEMS)) n_q <= n_q + NW'(1);
				else drop_q <= 1'b1;
			end
			if (cmd.start) begin
				cnt_q <= '0;
				k_q <= '0;
				sp_q <= (n_nx >= NW'(2)) ? NW'(1) : '0;
			end
			if (cmd.pop) sp_q <= sp_q - NW'(1);
			if (cmd.push_r | cmd.push_l) sp_q <= sp_q + NW'(1);
			if (cmd.inc_i | cmd.dec_j) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.emit) k_q <= k_q + NW'(1);
			if (cmd.clear) begin
				n_q <= '0; sp_q <= '0; k_q <= '0; drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			lo_q <= srdata[2*AW-1:AW];
			hi_q <= srdata[AW-1:0];
		end
		if (cmd.ld_pivot) begin
			i_q <= lo_x + 1;
			j_q <= hi_x;
		end
		if (piv_pend_q) piv_q <= rdata;
		if (cmd.inc_i) i_q <= i_q + 1;
		if (cmd.dec_j) j_q <= j_q - 1;
		if (cmd.rd_j & ~cmd.dec_j) ei_q <= rdata;
		if (cmd.wr_lo) ei_q <= piv_q;
	end

	assign sts.stk_empty = (sp_q == '0);
	assign sts.lo_ge_hi  = (srdata[2*AW-1:AW] >= srdata[AW-1:0]);
	assign sts.i_le_j    = (i_q <= j_q);
	assign sts.le_pivot  = ($signed(rdata) <= piv_q);
	assign sts.push_r_ok = (j_q + 1 < hi_x);
	assign sts.push_l_ok = (j_q - 1 > lo_x);
	assign sts.emit_last = (k_q + NW'(1) == n_q);
	assign out_value = rdata;
	assign out_count = cnt_q;
	assign out_drop  = drop_q;
endmodule
`default_nettype wire

// File: rtl/qsort_ctrl.sv
`default_nettype none
module qsort_ctrl import qsort_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output qs_cmd_t   cmd,
	input  wire qs_sts_t sts
);
	typedef enum logic [3:0] {
		S_LOAD, S_POP, S_POPW, S_RANGE, S_PIV, S_RI, S_TI, S_RJ, S_TJ,
		S_SWAPJ, S_SWAPW, S_FIN, S_FINW, S_PUSHL, S_ERD, S_EOUT
	} state_t;

	state_t st_q;
	logic   pushl_q;

	always_comb begin
		cmd = '0;
		in_ready = (st_q == S_LOAD);
		out_valid = (st_q == S_EOUT);
		case (st_q)
			S_LOAD: begin
				cmd.load = in_valid;
				cmd.start = in_valid & in_last;
			end
			S_RANGE: cmd.pop = 1'b1;
			S_PIV: cmd.ld_pivot = 1'b1;
			S_RI:  cmd.rd_i = 1'b1;
			S_TI: begin
				if (sts.i_le_j && sts.le_pivot) begin
					cmd.inc_i = 1'b1; cmd.rd_i = 1'b1;
				end else cmd.rd_j = 1'b1;
			end
			S_TJ: begin
				if (sts.i_le_j && !sts.le_pivot) begin
					cmd.dec_j = 1'b1; cmd.rd_j = 1'b1;
				end else if (sts.i_le_j) cmd.wr_i = 1'b1;
			end
			S_SWAPJ: cmd.wr_j = 1'b1;
			S_SWAPW: ;
			S_FIN: begin
				cmd.rd_j = 1'b1;
				cmd.push_r = sts.push_r_ok;
			end
			S_FINW: begin
				cmd.wr_lo = 1'b1;
			end
			S_PUSHL: begin
				cmd.wr_j = 1'b1;
				cmd.push_l = pushl_q;
			end
			S_ERD: ;
			S_EOUT: begin
				cmd.emit = out_ready;
				cmd.clear = out_ready & sts.emit_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			pushl_q <= 1'b0;
		end else begin
			case (st_q)
				S_LOAD: if (in_valid && in_last) st_q <= S_POP;
				S_POP:  st_q <= sts.stk_empty ? S_ERD : S_POPW;
				S_POPW: st_q <= S_RANGE;
				S_RANGE: st_q <= sts.lo_ge_hi ? S_POP : S_PIV;
				S_PIV:  st_q <= S_RI;
				S_RI:   st_q <= S_TI;
				S_TI:   if (!(sts.i_le_j && sts.le_pivot)) st_q <= S_TJ;
				S_TJ: begin
					if (sts.i_le_j && !sts.le_pivot) st_q <= S_TJ;
					else if (sts.i_le_j) st_q <= S_SWAPJ;
					else st_q <= S_FIN;
				end
				S_SWAPJ: st_q <= S_SWAPW;
				S_SWAPW: st_q <= S_RI;
				S_FIN:  st_q <= S_FINW;
				S_FINW: begin
					pushl_q <= sts.push_l_ok;
					st_q <= S_PUSHL;
				end
				S_PUSHL: st_q <= S_POP;
				S_ERD:  st_q <= S_EOUT;
				S_EOUT: if (out_ready) st_q <= sts.emit_last ? S_LOAD : S_ERD;
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/quicksort_with_comparison_count.sv
// Sorts a set of signed 16-bit values by quicksort. Values stream in one per
// cycle while s_tready is high; the one with tlast starts the sort. Values
// past MAX_ITEMS are dropped and flagged. Sorting runs on a single-port store
// read and a range stack; results then leave one at a time, each read from the store
// and held until m_tready. Each result carries the set's total scan-step count.
`default_nettype none
module quicksort_with_comparison_count import qsort_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // value
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // sorted_value, comparisons, overflow, pad
	output logic             m_tlast
);
	qs_cmd_t cmd;
	qs_sts_t sts;
	logic signed [VAL_W-1:0] ov;
	logic [CNT_W-1:0] oc;
	logic od;

	qsort_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_last(s_tlast),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .sts(sts)
	);
	qsort_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_value(s_tdata),
		.out_value(ov), .out_count(oc), .out_drop(od)
	);

	assign m_tdata = {3'b000, od, oc, ov};
	assign m_tlast = sts.emit_last;
endmodule
`default_nettype wire
